// ----- rtl/core/dts_pkg.sv -----
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the descending sorter with top-three average.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  localparam int VAL_W  = 32;
  localparam int SUM_W  = 34;   // three 32-bit values summed without overflow
  localparam int RANK_W = 6;
  localparam int TOP_N  = 3;    // values that go into the average

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [RANK_W-1:0]       rank_t;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;     // insert the broadcast value
    logic shift;   // move contents one cell toward the head
  } ctl_t;

  function automatic sum_t sext(value_t v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/descending_sorter_top_three.sv -----
// ----------------------------------------------------------------------------
// descending_sorter_top_three
// Insertion-chain sorter: loads a set of signed values, sends them out
// largest first with rank, end flag and the average of the three largest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one value per transfer, one transfer
//   per cycle while loading. The value is inserted into a chain of
//   MAX_VALUES cells. Values past MAX_VALUES are dropped
//   and reported with values_dropped on every result of the set.
//   A transfer with in_final_item set closes the set. in_stall then stays
//   high while the set drains; it drops in the cycle after the last result
//   is loaded into the output register.
//   Output channel (out_valid / out_stall): results leave the chain head
//   one per cycle while the output is not stalled. The run_end result also
//   waits for the divide-by-three unit, which the final transfer starts;
//   only in a set of exactly three values is it not yet done at that point.
//   A stall on the output holds the output register and the whole chain.
//   Reset empties the chain and clears the control state and out_valid but
//   not the output data registers; no clearing pass is used.
// ----------------------------------------------------------------------------
`default_nettype none

module descending_sorter_top_three #(
  parameter int MAX_VALUES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dts_pkg::value_t   in_sale_value,
  input  wire logic              in_final_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dts_pkg::value_t        out_sorted_value,
  output dts_pkg::rank_t         out_rank,
  output logic                   out_run_end,
  output dts_pkg::value_t        out_top_three_average,
  output logic                   out_too_few_values,
  output logic                   out_values_dropped
);
  import dts_pkg::*;

  localparam int CNT_W = $clog2(MAX_VALUES + 1);

  typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r, cnt_ins;
  logic             ovf_r, few_r, start_r;
  rank_t            rank_r;

  value_t           out_value_r, out_avg_r;
  logic             out_valid_r, out_end_r, out_few_r, out_ovf_r;
  rank_t            out_rank_r;

  ctl_t             ctl;
  value_t           val_w [MAX_VALUES];
  logic [MAX_VALUES-1:0] occ_w, keep_w;

  logic   in_xfer, full, out_free, last_one, load_out;
  sum_t   sum_w;
  value_t div_quot;
  logic   div_done;

  assign in_stall = (state_r != ST_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(MAX_VALUES));
  assign cnt_ins  = full ? count_r : count_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;
  assign last_one = (count_r == CNT_W'(1));
  // the end result waits for the average unless there is none to give
  assign load_out = (state_r == ST_DRAIN) && out_free && (!last_one || few_r || div_done);

  assign ctl.ins   = in_xfer && !full;
  assign ctl.shift = load_out;

  for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
    value_t lv, rv;
    logic   lo, lk, ro;
    if (i == 0) begin : g_head
      assign lv = '0;
      assign lo = 1'b0;
      assign lk = 1'b1;
    end else begin : g_body
      assign lv = val_w[i-1];
      assign lo = occ_w[i-1];
      assign lk = keep_w[i-1];
    end
    if (i == MAX_VALUES - 1) begin : g_tail
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_next
      assign rv = val_w[i+1];
      assign ro = occ_w[i+1];
    end
    dts_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .new_val_i   (in_sale_value),
      .left_val_i  (lv),
      .left_occ_i  (lo),
      .left_keep_i (lk),
      .right_val_i (rv),
      .right_occ_i (ro),
      .val_o       (val_w[i]),
      .occ_o       (occ_w[i]),
      .keep_o      (keep_w[i])
    );
  end

  // Top three sit in the head cells in the first drain cycle
  assign sum_w = sext(val_w[0]) + sext(val_w[1]) + sext(val_w[2]);

  dts_div3 u_div3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start_r),
    .sum_i   (sum_w),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      few_r       <= 1'b0;
      start_r     <= 1'b0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_xfer && in_final_item && (cnt_ins >= CNT_W'(TOP_N));
      case (state_r)
        ST_LOAD: begin
          if (in_xfer) begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= cnt_ins;
            end
            if (in_final_item) begin
              state_r <= ST_DRAIN;
              few_r   <= (cnt_ins < CNT_W'(TOP_N));
            end
          end
        end
        ST_DRAIN: begin
          if (load_out) begin
            count_r <= count_r - 1'b1;
            if (last_one) begin
              state_r <= ST_LOAD;
              ovf_r   <= 1'b0;
              rank_r  <= '0;
            end else begin
              rank_r  <= rank_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    if (load_out) begin
      out_value_r <= val_w[0];
      out_rank_r  <= rank_r;
      out_end_r   <= last_one;
      out_avg_r   <= (last_one && !few_r) ? div_quot : '0;
      out_few_r   <= few_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sorted_value      = out_value_r;
  assign out_rank              = out_rank_r;
  assign out_run_end           = out_end_r;
  assign out_top_three_average = out_avg_r;
  assign out_too_few_values    = out_few_r;
  assign out_values_dropped    = out_ovf_r;

endmodule

`default_nettype wire

// ----- rtl/core/dts_cell.sv -----
// ----------------------------------------------------------------------------
// dts_cell
// One slot of the insertion chain: keeps, takes the new value, or takes its
// left neighbor on insert; takes its right neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dts_pkg::ctl_t    ctl_i,
  input  wire dts_pkg::value_t  new_val_i,
  input  wire dts_pkg::value_t  left_val_i,
  input  wire logic             left_occ_i,
  input  wire logic             left_keep_i,
  input  wire dts_pkg::value_t  right_val_i,
  input  wire logic             right_occ_i,
  output dts_pkg::value_t       val_o,
  output logic                  occ_o,
  output logic                  keep_o
);
  import dts_pkg::*;

  value_t val_r, val_nxt;
  logic   occ_r, occ_nxt;

  // Hold when the stored value is not smaller; equal values keep arrival order
  assign keep_o = occ_r && (val_r >= new_val_i);
  assign val_o  = val_r;
  assign occ_o  = occ_r;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (ctl_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          val_nxt = new_val_i;
          occ_nxt = 1'b1;
        end else begin
          val_nxt = left_val_i;
          occ_nxt = left_occ_i;
        end
      end
    end else if (ctl_i.shift) begin
      val_nxt = right_val_i;
      occ_nxt = right_occ_i;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dts_div3.sv -----
// ----------------------------------------------------------------------------
// dts_div3
// Signed divide by three, truncating toward zero. The magnitude is multiplied
// by a 32-bit reciprocal of three and shifted; magnitude, product and quotient are registered in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_div3 (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start_i,
  input  wire dts_pkg::sum_t  sum_i,
  output dts_pkg::value_t     quot_o,
  output logic                done_o
);
  import dts_pkg::*;

  localparam int MAG_W  = SUM_W - 1;   // magnitude of a sum stays below 2**33
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SHIFT  = MAG_W;
  // ceil(2**33 / 3); exact for every magnitude below 2**33
  localparam logic [MUL_W-1:0] RECIP = 32'hAAAA_AAAB;

  logic [SUM_W-1:0]  abs_w;
  logic [PROD_W:0]   total_w;
  logic [MAG_W-1:0]  mag_r;
  logic [PROD_W-1:0] prod_r;
  logic [VAL_W-1:0]  quo_r;
  logic              hi_r, neg_r, mul_go_r, add_go_r, done_r;

  assign abs_w = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;

  // fold the top magnitude bit back in as a shifted copy of the reciprocal
  assign total_w = {1'b0, prod_r} +
                   {(hi_r ? {1'b0, RECIP} : {(MUL_W+1){1'b0}}), {MUL_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_go_r <= 1'b0;
      add_go_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      mul_go_r <= start_i;
      add_go_r <= mul_go_r;
      if (start_i) begin
        done_r <= 1'b0;
      end else if (add_go_r) begin
        done_r <= 1'b1;
      end
    end

    if (start_i) begin
      mag_r <= abs_w[MAG_W-1:0];
      neg_r <= sum_i[SUM_W-1];
    end
    // 32 x 32 product of the low magnitude bits
    if (mul_go_r) begin
      prod_r <= {{MUL_W{1'b0}}, mag_r[MUL_W-1:0]} * {{MUL_W{1'b0}}, RECIP};
      hi_r   <= mag_r[MAG_W-1];
    end
    if (add_go_r) begin
      quo_r <= total_w[PROD_W:SHIFT];
    end
  end

  assign quot_o = neg_r ? value_t'(-quo_r) : value_t'(quo_r);
  assign done_o = done_r;

endmodule

`default_nettype wire

// ----- rtl/core/dts_checker.sv -----
// ----------------------------------------------------------------------------
// dts_checker
// Port-level checks of the sorter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              in_final_item,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire dts_pkg::value_t   out_sorted_value,
  input wire dts_pkg::rank_t    out_rank,
  input wire logic              out_run_end,
  input wire dts_pkg::value_t   out_top_three_average,
  input wire logic              out_too_few_values,
  input wire logic              out_values_dropped
);
  import dts_pkg::*;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_value) && $stable(out_rank) &&
    $stable(out_run_end) && $stable(out_top_three_average) &&
    $stable(out_too_few_values) && $stable(out_values_dropped))
    else $error("stalled result changed");

  // a closed set stops input while it drains
  a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_final_item |=> in_stall)
    else $error("input taken right after final transfer");

  a_avg_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_run_end || out_too_few_values) |-> out_top_three_average == '0)
    else $error("average outside a valid end result");

  // within a set ranks advance by one
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_run_end |=> !out_valid || (out_rank == rank_t'($past(out_rank) + 1'b1)))
    else $error("rank did not advance");

endmodule

bind descending_sorter_top_three dts_checker u_dts_checker (.*);

`default_nettype wire
